FILE: rtl/mceo_pkg.sv
package mceo_pkg;

    // register file indexes
    typedef enum logic [2:0] {
        REG_OP_MODE    = 3'd0,
        REG_INDEX_MASK = 3'd1,
        REG_INDEX_MATCH = 3'd2,
        REG_HIT_RE     = 3'd3,
        REG_HIT_IM     = 3'd4,
        REG_MISS_RE    = 3'd5,
        REG_MISS_IM    = 3'd6
    } reg_addr_t;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    localparam int FRAC_BITS   = 24;
    localparam int QUO_BITS    = 33;              // quotient bits produced by the divider
    localparam int LOW_BITS    = QUO_BITS - FRAC_BITS; // low dividend bits shifted into the divider
    localparam int ARITH_STAGES = 4;
    localparam int PIPE_LEN    = ARITH_STAGES + QUO_BITS + 1;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN = 32'h8000_0000;

    localparam logic [31:0] HIT_RE_RESET = 32'h0100_0000;

    typedef logic signed [31:0] q824_t;

    typedef struct packed {
        op_t          op;
        logic [31:0]  mask;
        logic [31:0]  match;
        q824_t        hit_re;
        q824_t        hit_im;
        q824_t        miss_re;
        q824_t        miss_im;
    } cfg_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } clamp_t;

    // everything that travels beside the divider
    typedef struct packed {
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        sat;
        logic        hit;
        logic        last;
        op_t         op;
        logic        divz;
        logic        neg_re;
        logic        neg_im;
        logic        ovf_re;
        logic        ovf_im;
    } side_t;

    // divider operands of one component
    typedef struct packed {
        logic [63:0]          rem;
        logic [LOW_BITS-1:0]  low;
        logic [63:0]          den;
    } div_in_t;

    // clamp a signed value to 32 bits
    function automatic clamp_t clamp65(input logic signed [64:0] v);
        clamp_t r;
        if (v[64:31] == '0 || v[64:31] == '1)
        begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        else
        begin
            r.sat = 1'b1;
            r.val = v[64] ? NEG_MIN : POS_MAX;
        end
        return r;
    endfunction

    // sign and quotient magnitude to a clamped 32-bit value
    function automatic clamp_t clamp_mag(input logic neg, input logic ovf,
                                         input logic [QUO_BITS-1:0] q);
        clamp_t r;
        logic   big;
        big = ovf || q[32] || (!neg && q[31]) || (neg && q[31] && (q[30:0] != '0));
        if (big)
        begin
            r.sat = 1'b1;
            r.val = neg ? NEG_MIN : POS_MAX;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = neg ? (32'd0 - q[31:0]) : q[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/mceo_arith.sv
module mceo_arith #(
    parameter int INDEX_BITS = 32
) (
    input  logic                  clk,
    input  logic                  en,
    input  mceo_pkg::cfg_t        cfg,
    input  logic [31:0]           elem_index,
    input  mceo_pkg::q824_t       amp_re,
    input  mceo_pkg::q824_t       amp_im,
    input  logic                  last_in,
    output mceo_pkg::side_t       side,
    output mceo_pkg::div_in_t     div_re,
    output mceo_pkg::div_in_t     div_im
);

    localparam int CMP_BITS = (INDEX_BITS < 32) ? INDEX_BITS : 32;

    // stage 1: index compare and coefficient select
    mceo_pkg::q824_t a_re_reg, a_im_reg, c_re_reg, c_im_reg;
    logic            hit1_reg, last1_reg;
    logic            hit_next;

    assign hit_next = ((elem_index[CMP_BITS-1:0] & cfg.mask[CMP_BITS-1:0])
                       == cfg.match[CMP_BITS-1:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_re_reg  <= amp_re;
            a_im_reg  <= amp_im;
            c_re_reg  <= hit_next ? cfg.hit_re : cfg.miss_re;
            c_im_reg  <= hit_next ? cfg.hit_im : cfg.miss_im;
            hit1_reg  <= hit_next;
            last1_reg <= last_in;
        end
    end

    // stage 2: partial products, sums and zero-divisor check
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;
    logic signed [32:0] s_re_reg, s_im_reg;
    logic               divz2_reg, hit2_reg, last2_reg;
    logic signed [32:0] s_re_next, s_im_next;

    always_comb
    begin
        if (cfg.op == mceo_pkg::OP_SUB)
        begin
            s_re_next = {a_re_reg[31], a_re_reg} - {c_re_reg[31], c_re_reg};
            s_im_next = {a_im_reg[31], a_im_reg} - {c_im_reg[31], c_im_reg};
        end
        else
        begin
            s_re_next = {a_re_reg[31], a_re_reg} + {c_re_reg[31], c_re_reg};
            s_im_next = {a_im_reg[31], a_im_reg} + {c_im_reg[31], c_im_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rr_reg  <= a_re_reg * c_re_reg;
            p_ii_reg  <= a_im_reg * c_im_reg;
            p_ri_reg  <= a_re_reg * c_im_reg;
            p_ir_reg  <= a_im_reg * c_re_reg;
            sq_r_reg  <= c_re_reg * c_re_reg;
            sq_i_reg  <= c_im_reg * c_im_reg;
            s_re_reg  <= s_re_next;
            s_im_reg  <= s_im_next;
            divz2_reg <= (c_re_reg == '0) && (c_im_reg == '0);
            hit2_reg  <= hit1_reg;
            last2_reg <= last1_reg;
        end
    end

    // stage 3: combine products into real and imaginary parts
    logic signed [64:0] m_re_reg, m_im_reg, d_re_reg, d_im_reg;
    logic [63:0]        den_reg;
    logic signed [32:0] s3_re_reg, s3_im_reg;
    logic               divz3_reg, hit3_reg, last3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_re_reg  <= {p_rr_reg[63], p_rr_reg} - {p_ii_reg[63], p_ii_reg};
            m_im_reg  <= {p_ri_reg[63], p_ri_reg} + {p_ir_reg[63], p_ir_reg};
            d_re_reg  <= {p_rr_reg[63], p_rr_reg} + {p_ii_reg[63], p_ii_reg};
            d_im_reg  <= {p_ir_reg[63], p_ir_reg} - {p_ri_reg[63], p_ri_reg};
            den_reg   <= sq_r_reg + sq_i_reg;
            s3_re_reg <= s_re_reg;
            s3_im_reg <= s_im_reg;
            divz3_reg <= divz2_reg;
            hit3_reg  <= hit2_reg;
            last3_reg <= last2_reg;
        end
    end

    // stage 4: clamp non-divide results, split divide numerators
    mceo_pkg::clamp_t   cl_re, cl_im;
    logic signed [64:0] sh_re, sh_im;
    logic               neg_re, neg_im;
    logic [63:0]        mag_re, mag_im;
    logic signed [64:0] abs_re, abs_im;

    always_comb
    begin
        sh_re = m_re_reg >>> mceo_pkg::FRAC_BITS;
        sh_im = m_im_reg >>> mceo_pkg::FRAC_BITS;
        if (cfg.op == mceo_pkg::OP_MUL)
        begin
            cl_re = mceo_pkg::clamp65(sh_re);
            cl_im = mceo_pkg::clamp65(sh_im);
        end
        else
        begin
            cl_re = mceo_pkg::clamp65({{32{s3_re_reg[32]}}, s3_re_reg});
            cl_im = mceo_pkg::clamp65({{32{s3_im_reg[32]}}, s3_im_reg});
        end
        neg_re = d_re_reg[64];
        neg_im = d_im_reg[64];
        abs_re = neg_re ? -d_re_reg : d_re_reg;
        abs_im = neg_im ? -d_im_reg : d_im_reg;
        mag_re = abs_re[63:0];
        mag_im = abs_im[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side.res_re <= cl_re.val;
            side.res_im <= cl_im.val;
            side.sat    <= cl_re.sat | cl_im.sat;
            side.hit    <= hit3_reg;
            side.last   <= last3_reg;
            side.op     <= cfg.op;
            side.divz   <= divz3_reg;
            side.neg_re <= neg_re;
            side.neg_im <= neg_im;
            side.ovf_re <= {9'd0, mag_re[63:mceo_pkg::LOW_BITS]} >= den_reg;
            side.ovf_im <= {9'd0, mag_im[63:mceo_pkg::LOW_BITS]} >= den_reg;
            div_re.rem  <= {9'd0, mag_re[63:mceo_pkg::LOW_BITS]};
            div_re.low  <= mag_re[mceo_pkg::LOW_BITS-1:0];
            div_re.den  <= den_reg;
            div_im.rem  <= {9'd0, mag_im[63:mceo_pkg::LOW_BITS]};
            div_im.low  <= mag_im[mceo_pkg::LOW_BITS-1:0];
            div_im.den  <= den_reg;
        end
    end

endmodule

FILE: rtl/mceo_div.sv
module mceo_div (
    input  logic                             clk,
    input  logic                             en,
    input  mceo_pkg::div_in_t                din,
    output logic [mceo_pkg::QUO_BITS-1:0]    quo
);

    localparam int N = mceo_pkg::QUO_BITS;

    mceo_pkg::div_in_t  st_reg [N];
    logic [N-1:0]       q_reg  [N];

    // one quotient bit per stage, restoring long division
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        mceo_pkg::div_in_t prev;
        logic [N-1:0]      q_prev;
        logic              bit_in;
        logic [64:0]       trial;
        logic [64:0]       diff;
        logic              take;

        if (k == 0)
        begin : g_first
            assign prev   = din;
            assign q_prev = '0;
        end
        else
        begin : g_next
            assign prev   = st_reg[k-1];
            assign q_prev = q_reg[k-1];
        end

        always_comb
        begin
            bit_in = prev.low[mceo_pkg::LOW_BITS-1];
            trial  = {prev.rem, bit_in};
            diff   = trial - {1'b0, prev.den};
            take   = !diff[64];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k].rem <= take ? diff[63:0] : trial[63:0];
                st_reg[k].low <= {prev.low[mceo_pkg::LOW_BITS-2:0], 1'b0};
                st_reg[k].den <= prev.den;
                q_reg[k]      <= {q_prev[N-2:0], take};
            end
        end
    end

    assign quo = q_reg[N-1];

endmodule

FILE: rtl/masked_complex_elementwise_op_top.sv
// masked complex elementwise operation on a stream of amplitudes
// input channel s_*: one beat per amplitude with its element index, tlast marks
// the final element of the vector; output channel m_*: one result beat per input
// beat, in order, tlast copied through
// each beat picks the hit or miss coefficient by (index & mask) == match and
// adds, subtracts, multiplies or divides the amplitude by it in Q8.24
// configuration: write cfg_we with cfg_addr / cfg_wdata while the stream is idle
// pipeline: 4 arithmetic stages, 33 stages of the restoring divider, one bit
// each, and the output register
// throughput: one beat per cycle unless the output stalls; the divider pipeline sets the depth
// stall: when a result waits with m_tready low the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost or repeated
// reset: pipeline empties, registers return to multiply by 1.0 with mask 0,
// match 0 and miss coefficient 0
module masked_complex_elementwise_op_top #(
    parameter int INDEX_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // elem_index, amp_re, amp_im
    input  logic        s_tlast,   // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // res_re, res_im
    output logic [2:0]  m_tuser,   // matched, status
    output logic        m_tlast    // last_out
);

    localparam int PL = mceo_pkg::PIPE_LEN;
    localparam int NQ = mceo_pkg::QUO_BITS;

    // configuration registers
    mceo_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op      <= mceo_pkg::OP_MUL;
            cfg_reg.mask    <= '0;
            cfg_reg.match   <= '0;
            cfg_reg.hit_re  <= mceo_pkg::HIT_RE_RESET;
            cfg_reg.hit_im  <= '0;
            cfg_reg.miss_re <= '0;
            cfg_reg.miss_im <= '0;
        end
        else if (cfg_we)
        begin
            case (mceo_pkg::reg_addr_t'(cfg_addr))
                mceo_pkg::REG_OP_MODE:     cfg_reg.op      <= mceo_pkg::op_t'(cfg_wdata[1:0]);
                mceo_pkg::REG_INDEX_MASK:  cfg_reg.mask    <= cfg_wdata;
                mceo_pkg::REG_INDEX_MATCH: cfg_reg.match   <= cfg_wdata;
                mceo_pkg::REG_HIT_RE:      cfg_reg.hit_re  <= cfg_wdata;
                mceo_pkg::REG_HIT_IM:      cfg_reg.hit_im  <= cfg_wdata;
                mceo_pkg::REG_MISS_RE:     cfg_reg.miss_re <= cfg_wdata;
                mceo_pkg::REG_MISS_IM:     cfg_reg.miss_im <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: move unless the output beat is stuck
    logic          en;
    logic [PL-1:0] vld_reg;

    assign en       = !vld_reg[PL-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PL-2:0], s_tvalid};
    end

    // arithmetic front stages
    mceo_pkg::side_t   side_a;
    mceo_pkg::div_in_t div_re, div_im;

    mceo_arith #(
        .INDEX_BITS (INDEX_BITS)
    ) u_arith (
        .clk        (clk),
        .en         (en),
        .cfg        (cfg_reg),
        .elem_index (s_tdata[31:0]),
        .amp_re     (s_tdata[63:32]),
        .amp_im     (s_tdata[95:64]),
        .last_in    (s_tlast),
        .side       (side_a),
        .div_re     (div_re),
        .div_im     (div_im)
    );

    // dividers for both components
    logic [NQ-1:0] q_re, q_im;

    mceo_div u_div_re (
        .clk (clk),
        .en  (en),
        .din (div_re),
        .quo (q_re)
    );

    mceo_div u_div_im (
        .clk (clk),
        .en  (en),
        .din (div_im),
        .quo (q_im)
    );

    // side information delayed to match the dividers
    mceo_pkg::side_t side_reg [NQ];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_a;
            for (int i = 1; i < NQ; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // final select and output register
    mceo_pkg::side_t  sd;
    mceo_pkg::clamp_t qc_re, qc_im;
    logic [31:0]      re_next, im_next;
    mceo_pkg::status_t st_next;
    logic [31:0]      re_reg, im_reg;
    mceo_pkg::status_t st_reg;
    logic             hit_reg, last_reg;

    always_comb
    begin
        sd    = side_reg[NQ-1];
        qc_re = mceo_pkg::clamp_mag(sd.neg_re, sd.ovf_re, q_re);
        qc_im = mceo_pkg::clamp_mag(sd.neg_im, sd.ovf_im, q_im);
        if (sd.op == mceo_pkg::OP_DIV)
        begin
            if (sd.divz)
            begin
                re_next = '0;
                im_next = '0;
                st_next = mceo_pkg::ST_DIVZ;
            end
            else
            begin
                re_next = qc_re.val;
                im_next = qc_im.val;
                st_next = (qc_re.sat || qc_im.sat) ? mceo_pkg::ST_SAT : mceo_pkg::ST_OK;
            end
        end
        else
        begin
            re_next = sd.res_re;
            im_next = sd.res_im;
            st_next = sd.sat ? mceo_pkg::ST_SAT : mceo_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg   <= re_next;
            im_reg   <= im_next;
            st_reg   <= st_next;
            hit_reg  <= sd.hit;
            last_reg <= sd.last;
        end
    end

    assign m_tdata = {im_reg, re_reg};
    assign m_tuser = {st_reg, hit_reg};
    assign m_tlast = last_reg;

`ifndef NO_ASSERTIONS
    // zero divisor gives a zero result
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:1] == mceo_pkg::ST_DIVZ) |-> (m_tdata == '0))
        else $error("division by zero result not zero");

    // a saturated beat has a component at a limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:1] == mceo_pkg::ST_SAT) |->
            (re_reg == mceo_pkg::POS_MAX) || (re_reg == mceo_pkg::NEG_MIN) ||
            (im_reg == mceo_pkg::POS_MAX) || (im_reg == mceo_pkg::NEG_MIN))
        else $error("saturated status without clamped component");

    // an accepted beat enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted beat lost at pipeline entry");

    // a stalled output beat leaves the pipeline frozen
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");
`endif

endmodule

FILE: test/tb_masked_complex_elementwise_op_top.sv
`timescale 1ns / 100ps

module tb_masked_complex_elementwise_op_top;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 45;
    localparam int  PHASES      = 9;
    localparam int  PHASE_BEATS = 50;
    localparam int  DIR_ROWS    = 12;
    localparam logic signed [127:0] Q_HI = 128'sd2147483647;
    localparam logic signed [127:0] Q_LO = -128'sd2147483648;

    typedef struct packed {
        logic [31:0]       re;
        logic [31:0]       im;
        logic              hit;
        mceo_pkg::status_t st;
        logic              last;
    } amp_result_t;

    typedef struct packed {
        mceo_pkg::op_t     op;
        logic [31:0]       mask;
        logic [31:0]       idx;
        logic [31:0]       re;
        logic [31:0]       im;
        logic              last;
        logic              known;
        logic [31:0]       exp_re;
        logic [31:0]       exp_im;
        logic              exp_hit;
        mceo_pkg::status_t exp_st;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // shadow copy of the register file
    mceo_pkg::op_t sh_op;
    logic [31:0]   sh_mask;
    logic [31:0]   sh_match;
    logic [31:0]   sh_hre, sh_him, sh_mre, sh_mim;

    amp_result_t pending_q[$];
    dir_row_t    rows[DIR_ROWS];
    int          mismatches;
    int          failed;
    int          cycles;
    bit          hold_req;
    bit          no_gaps;

    masked_complex_elementwise_op_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // clamp a wide signed value to Q8.24
    function automatic logic [31:0] clamp_q(input logic signed [127:0] v, inout logic sat);
        if (v > Q_HI)
        begin
            sat = 1'b1;
            return mceo_pkg::POS_MAX;
        end
        if (v < Q_LO)
        begin
            sat = 1'b1;
            return mceo_pkg::NEG_MIN;
        end
        return v[31:0];
    endfunction

    // quotient truncated toward zero with 24 fraction bits
    function automatic logic signed [127:0] frac_div(input logic signed [127:0] n,
                                                    input logic [127:0] den);
        logic        neg;
        logic [127:0] mag;
        logic [127:0] q;
        neg = n < 0;
        mag = neg ? -n : n;
        q   = (mag << mceo_pkg::FRAC_BITS) / den;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic amp_result_t scale_amplitude(input logic [31:0] idx,
                                                    input logic [31:0] are,
                                                    input logic [31:0] aim,
                                                    input logic last);
        amp_result_t r;
        logic              sat;
        logic signed [127:0] ar, ai, cr, ci, n_re, n_im;
        logic [127:0]      den;
        r.hit  = (idx & sh_mask) == sh_match;
        r.last = last;
        r.st   = mceo_pkg::ST_OK;
        r.re   = '0;
        r.im   = '0;
        sat    = 1'b0;
        ar = $signed(are);
        ai = $signed(aim);
        cr = $signed(r.hit ? sh_hre : sh_mre);
        ci = $signed(r.hit ? sh_him : sh_mim);
        case (sh_op)
            mceo_pkg::OP_ADD:
            begin
                r.re = clamp_q(ar + cr, sat);
                r.im = clamp_q(ai + ci, sat);
            end
            mceo_pkg::OP_SUB:
            begin
                r.re = clamp_q(ar - cr, sat);
                r.im = clamp_q(ai - ci, sat);
            end
            mceo_pkg::OP_MUL:
            begin
                r.re = clamp_q((ar * cr - ai * ci) >>> mceo_pkg::FRAC_BITS, sat);
                r.im = clamp_q((ar * ci + ai * cr) >>> mceo_pkg::FRAC_BITS, sat);
            end
            default:
            begin
                if (cr == 0 && ci == 0)
                    r.st = mceo_pkg::ST_DIVZ;
                else
                begin
                    den  = cr * cr + ci * ci;
                    n_re = ar * cr + ai * ci;
                    n_im = ai * cr - ar * ci;
                    r.re = clamp_q(frac_div(n_re, den), sat);
                    r.im = clamp_q(frac_div(n_im, den), sat);
                end
            end
        endcase
        if (r.st == mceo_pkg::ST_OK && sat)
            r.st = mceo_pkg::ST_SAT;
        return r;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 6))
            0: return mceo_pkg::POS_MAX;
            1: return mceo_pkg::NEG_MIN;
            2: return 32'd0;
            3: return $urandom_range(0, 1 << 26);
            4: return -$urandom_range(0, 1 << 26);
            default: return $urandom;
        endcase
    endfunction

    // write the whole register file, called at a clock edge
    task automatic set_config(input mceo_pkg::op_t op, input logic [31:0] mask,
                              input logic [31:0] match,
                              input logic [31:0] hre, input logic [31:0] him,
                              input logic [31:0] mre, input logic [31:0] mim);
        logic [31:0] vals[7];
        vals = '{32'(op), mask, match, hre, him, mre, mim};
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= 3'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        sh_op    = op;
        sh_mask  = mask;
        sh_match = match;
        sh_hre   = hre;
        sh_him   = him;
        sh_mre   = mre;
        sh_mim   = mim;
    endtask

    // let every outstanding result arrive, then let the pipe settle
    task automatic drain();
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // offer one beat, with a random gap in front, until accepted
    task automatic send_beat(input logic [31:0] idx, input logic [31:0] re,
                             input logic [31:0] im, input logic last,
                             input bit known, input amp_result_t typed);
        logic got;
        while (!no_gaps && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re, idx};
        s_tlast  <= last;
        do
        begin
            @(negedge clk);
            got = s_tready;
            @(posedge clk);
        end
        while (!got);
        pending_q.push_back(known ? typed : scale_amplitude(idx, re, im, last));
    endtask

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        static int  hold_left = 0;
        static bit  hold_done = 0;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 31);
        end
    end

    // result checker, sampled midway while signals are steady
    always @(negedge clk)
    begin
        amp_result_t want;
        amp_result_t seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = '{m_tdata[31:0], m_tdata[63:32], m_tuser[0],
                     mceo_pkg::status_t'(m_tuser[2:1]), m_tlast};
            if (pending_q.size() == 0)
            begin
                failed = 1;
                if (mismatches < 10)
                    $display("unexpected result beat %h", seen);
                mismatches++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (seen != want)
                begin
                    failed = 1;
                    if (mismatches < 10)
                        $display("mismatch: re %h/%h im %h/%h hit %b/%b st %0d/%0d last %b/%b",
                                 want.re, seen.re, want.im, seen.im, want.hit, seen.hit,
                                 want.st, seen.st, want.last, seen.last);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_masked_complex_elementwise_op_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        mceo_pkg::op_t op;
        logic [31:0]   mask;
        logic [31:0]   match;
        logic [31:0]   mre, mim;
        amp_result_t   typed;
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        mismatches = 0;
        failed     = 0;
        cycles     = 0;
        hold_req   = 0;
        no_gaps    = 0;
        sh_op    = mceo_pkg::OP_MUL;
        sh_mask  = '0;
        sh_match = '0;
        sh_hre   = mceo_pkg::HIT_RE_RESET;
        sh_him   = '0;
        sh_mre   = '0;
        sh_mim   = '0;

        // hit coefficient 1.0, miss coefficient 0, match 0
        rows[0]  = '{mceo_pkg::OP_MUL, 0, 32'h0, mceo_pkg::POS_MAX, mceo_pkg::NEG_MIN, 0, 1,
                     mceo_pkg::POS_MAX, mceo_pkg::NEG_MIN, 1, mceo_pkg::ST_OK};
        rows[1]  = '{mceo_pkg::OP_MUL, 0, 32'hFFFF_FFFF, 0, 1, 1, 1, 0, 1, 1,
                     mceo_pkg::ST_OK};
        rows[2]  = '{mceo_pkg::OP_ADD, 0, 32'h5, mceo_pkg::POS_MAX, 0, 0, 1,
                     mceo_pkg::POS_MAX, 0, 1, mceo_pkg::ST_SAT};
        rows[3]  = '{mceo_pkg::OP_SUB, 0, 32'h6, mceo_pkg::NEG_MIN, 0, 0, 1,
                     mceo_pkg::NEG_MIN, 0, 1, mceo_pkg::ST_SAT};
        rows[4]  = '{mceo_pkg::OP_SUB, 0, 32'h7, 32'h0100_0000, 32'h1234_5678, 0, 1, 0,
                     32'h1234_5678, 1, mceo_pkg::ST_OK};
        rows[5]  = '{mceo_pkg::OP_DIV, 1, 32'h1, 32'h1234_5678, 32'h0000_0042, 0, 1, 0, 0, 0,
                     mceo_pkg::ST_DIVZ};
        rows[6]  = '{mceo_pkg::OP_DIV, 1, 32'h0, 32'h1234_5678, mceo_pkg::NEG_MIN, 0, 1,
                     32'h1234_5678, mceo_pkg::NEG_MIN, 1, mceo_pkg::ST_OK};
        rows[7]  = '{mceo_pkg::OP_DIV, 1, 32'hFFFF_FFFF, mceo_pkg::NEG_MIN, mceo_pkg::POS_MAX,
                     1, 1, 0, 0, 0, mceo_pkg::ST_DIVZ};
        rows[8]  = '{mceo_pkg::OP_DIV, 1, 32'h2, 32'hFFFF_FFFF, 32'h0080_0000, 0, 0, 0, 0, 0,
                     mceo_pkg::ST_OK};
        rows[9]  = '{mceo_pkg::OP_SUB, 1, 32'h3, 32'hDEAD_BEEF, 32'h0BAD_F00D, 0, 1,
                     32'hDEAD_BEEF, 32'h0BAD_F00D, 0, mceo_pkg::ST_OK};
        rows[10] = '{mceo_pkg::OP_MUL, 1, 32'h8000_0001, mceo_pkg::POS_MAX, mceo_pkg::POS_MAX,
                     0, 1, 0, 0, 0, mceo_pkg::ST_OK};
        rows[11] = '{mceo_pkg::OP_ADD, 1, 32'h8000_0000, 32'hFF00_0000, 32'h7F00_0000, 1, 0,
                     0, 0, 0, mceo_pkg::ST_OK};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i > 0 && (rows[i].op != sh_op || rows[i].mask != sh_mask))
            begin
                s_tvalid <= 1'b0;
                drain();
                set_config(rows[i].op, rows[i].mask, 0, mceo_pkg::HIT_RE_RESET, 0, 0, 0);
            end
            typed = '{rows[i].exp_re, rows[i].exp_im, rows[i].exp_hit, rows[i].exp_st,
                      rows[i].last};
            send_beat(rows[i].idx, rows[i].re, rows[i].im, rows[i].last, rows[i].known, typed);
        end

        // random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            s_tvalid <= 1'b0;
            drain();
            op = (p < 4) ? mceo_pkg::op_t'(p) : mceo_pkg::op_t'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: mask = '0;
                1: mask = 32'hFFFF_FFFF;
                2: mask = 32'h1 << $urandom_range(0, 31);
                default: mask = $urandom;
            endcase
            match = ($urandom_range(0, 4) == 0) ? 32'($urandom) : (mask & $urandom);
            mre = rand_q();
            mim = ($urandom_range(0, 2) == 0) ? 32'd0 : rand_q();
            if (op == mceo_pkg::OP_DIV && $urandom_range(0, 1))
                mre = '0;
            if (p == 0)
                set_config(op, mask, match, mceo_pkg::POS_MAX, mceo_pkg::NEG_MIN,
                           mceo_pkg::NEG_MIN, mceo_pkg::POS_MAX);
            else if (p == 1)
                set_config(op, 32'hFFFF_FFFF, 32'hFFFF_FFFF, mceo_pkg::NEG_MIN,
                           mceo_pkg::POS_MAX, 0, 0);
            else
                set_config(op, mask, match, rand_q(), rand_q(), mre, mim);
            no_gaps  = (p == 3);
            hold_req = (p == 2);
            for (int k = 0; k < PHASE_BEATS; k++)
                send_beat($urandom_range(0, 1) ? 32'($urandom) : 32'(match | ($urandom & ~mask)),
                          rand_q(), rand_q(), $urandom_range(0, 7) == 0, 0, typed);
        end
        s_tvalid <= 1'b0;
        no_gaps = 0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (!failed && pending_q.size() == 0)
            $display("tb_masked_complex_elementwise_op_top: PASS");
        else
            $display("tb_masked_complex_elementwise_op_top: FAIL");
        $finish;
    end

endmodule
